// ===== rtl/assert_macros.svh =====
// Assertion helpers; clock clk, reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication.
`define RAG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rag assertion failed");
// Next-cycle implication.
`define RAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rag assertion failed");
`endif

// ===== rtl/rag_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rag_pkg;
    localparam int NUM_LOCKS    = 10;
    localparam int NUM_PROCS    = 20;
    localparam int NUM_NODES    = 30;
    localparam int RESULT_LIMIT = 21;
    localparam int NODE_W       = $clog2(NUM_NODES);
    localparam int CNT_W        = $clog2(NUM_NODES + 1);
    localparam int RES_W        = $clog2(RESULT_LIMIT);
    localparam int PROC_W       = 5;
    localparam int LOCK_W       = 4;

    typedef logic [NUM_NODES-1:0] row_t;

    typedef enum logic [1:0] {
        MARK_WHITE,
        MARK_GREY,
        MARK_BLACK
    } mark_t;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_ALLOC,
        OP_RELEASE,
        OP_DETECT
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD1,
        S_UPD2_RD,
        S_UPD2_WR,
        S_ACK,
        S_INIT,
        S_ROOT,
        S_STEP,
        S_TEST,
        S_WALK,
        S_HOLD,
        S_CLEAR,
        S_REPORT,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/rag_deadlock_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Handshake          | Payload
// input    | in  | in_valid/in_stall  | op, proc_id, lock_num
// result   | out | out_valid/out_stall| deadlock_found, victim_proc, freed_lock, last
//
// Update beat (request/allocate/release): IDLE reads the row, UPD1 writes it back, ACK
// sends the ack beat; allocate also rewrites the process row (UPD2_RD, UPD2_WR) and an
// out-of-range index goes straight to ACK. Each edge-matrix row is a read-modify-write
// through the registered row memory. Detect: a column probe takes STEP and TEST, a
// parent-chain step WALK, a recovered cycle holder lookup, column-clear sweep and report.
// Reset clears row valid bits at once (rows read as zero until written); no sweep.
// Output stall holds the FSM only where it must emit a beat; one result register.
module rag_deadlock_detector (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               op,
    input  wire logic [rag_pkg::PROC_W-1:0] proc_id,
    input  wire logic [rag_pkg::LOCK_W-1:0] lock_num,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          deadlock_found,
    output logic [rag_pkg::PROC_W-1:0]    victim_proc,
    output logic [rag_pkg::LOCK_W-1:0]    freed_lock,
    output logic                          last
);
    localparam int NN = rag_pkg::NUM_NODES;
    localparam int NW = rag_pkg::NODE_W;
    localparam int CW = rag_pkg::CNT_W;

    // Edge matrix memory, one row per node
    rag_pkg::row_t mem [NN];
    rag_pkg::row_t rd_data_reg;
    logic          rd_ok_reg;
    logic [NN-1:0] row_valid_reg;
    logic          rd_en, wr_en;
    logic [NW-1:0] rd_addr, wr_addr;
    rag_pkg::row_t wr_data, row;

    rag_pkg::state_t state_reg, state_next;
    rag_pkg::op_t    op_reg, op_next;
    logic [NW-1:0]   pn_reg, pn_next, ln_reg, ln_next;

    // Search state
    rag_pkg::mark_t  vis_reg [NN];
    rag_pkg::mark_t  vis_next [NN];
    logic [NN-1:0]   came_ok_reg, came_ok_next;
    logic [NW-1:0]   came_reg [NN];
    logic [NW-1:0]   came_next [NN];
    logic [NW-1:0]   stack_reg [NN];
    logic [NW-1:0]   stack_next [NN];
    logic [CW-1:0]   ncol_reg [NN];
    logic [CW-1:0]   ncol_next [NN];
    logic [CW-1:0]   root_reg, root_next, sd_reg, sd_next, steps_reg, steps_next;
    logic [CW-1:0]   clr_reg, clr_next;
    logic [NW-1:0]   c_reg, c_next, top_reg, top_next, i_reg, i_next;
    logic [NW-1:0]   chosen_reg, chosen_next, holder_reg, holder_next;
    logic            chosen_ok_reg, chosen_ok_next;
    logic [rag_pkg::RES_W-1:0] n_reg, n_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      found_reg, found_next, last_reg, last_next;
    logic [rag_pkg::PROC_W-1:0] victim_reg, victim_next;
    logic [rag_pkg::LOCK_W-1:0] lock_reg, lock_next;

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;
    assign row      = rd_ok_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg     <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_ok_reg <= row_valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [NW-1:0]  sp, top, nx, h;
        logic [CW-1:0]  cc;
        logic           fin, ch_ok, h_found, ok;
        rag_pkg::mark_t vrd;
        logic [NW-1:0]  vaddr;
        logic [6:0]     pn_wide;
        rag_pkg::row_t  cbit;

        state_next     = state_reg;
        op_next        = op_reg;
        pn_next        = pn_reg;
        ln_next        = ln_reg;
        vis_next       = vis_reg;
        came_ok_next   = came_ok_reg;
        came_next      = came_reg;
        stack_next     = stack_reg;
        ncol_next      = ncol_reg;
        root_next      = root_reg;
        sd_next        = sd_reg;
        steps_next     = steps_reg;
        clr_next       = clr_reg;
        c_next         = c_reg;
        top_next       = top_reg;
        i_next         = i_reg;
        chosen_next    = chosen_reg;
        chosen_ok_next = chosen_ok_reg;
        holder_next    = holder_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && out_stall;
        found_next     = found_reg;
        last_next      = last_reg;
        victim_next    = victim_reg;
        lock_next      = lock_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        in_stall       = (state_reg != rag_pkg::S_IDLE);

        sp      = NW'(sd_reg - CW'(1));
        top     = stack_reg[sp];
        cc      = ncol_reg[sp];
        nx      = came_reg[i_reg];
        fin     = 1'b0;
        ch_ok   = chosen_ok_reg;
        h       = '0;
        h_found = 1'b0;
        vaddr   = (state_reg == rag_pkg::S_ROOT) ? root_reg[NW-1:0] : c_reg;
        vrd     = vis_reg[vaddr];
        pn_wide = 7'(proc_id) + 7'(rag_pkg::NUM_LOCKS);
        ok      = (proc_id < rag_pkg::PROC_W'(rag_pkg::NUM_PROCS))
                  && (6'(lock_num) < 6'(rag_pkg::NUM_LOCKS))
                  && (pn_wide < 7'(NN));
        cbit    = rag_pkg::row_t'(1) << holder_reg;
        for (int c = rag_pkg::NUM_LOCKS; c < NN; c++)
        begin
            if (row[c])
            begin
                h_found = 1'b1;
                h       = NW'(c);
            end
        end

        case (state_reg)
            rag_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = rag_pkg::op_t'(op);
                    pn_next = NW'(pn_wide);
                    ln_next = NW'(lock_num);
                    if (rag_pkg::op_t'(op) == rag_pkg::OP_DETECT)
                    begin
                        state_next = rag_pkg::S_INIT;
                    end
                    else if (!ok)
                    begin
                        state_next = rag_pkg::S_ACK;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = (rag_pkg::op_t'(op) == rag_pkg::OP_REQUEST) ?
                                     NW'(pn_wide) : NW'(lock_num);
                        state_next = rag_pkg::S_UPD1;
                    end
                end
            end
            rag_pkg::S_UPD1:
            begin
                wr_en      = 1'b1;
                state_next = rag_pkg::S_ACK;
                case (op_reg)
                    rag_pkg::OP_REQUEST:
                    begin
                        wr_addr = pn_reg;
                        wr_data = row | (rag_pkg::row_t'(1) << ln_reg);
                    end
                    rag_pkg::OP_ALLOC:
                    begin
                        wr_addr    = ln_reg;
                        wr_data    = row | (rag_pkg::row_t'(1) << pn_reg);
                        state_next = rag_pkg::S_UPD2_RD;
                    end
                    default:
                    begin
                        wr_addr = ln_reg;
                        wr_data = row & ~(rag_pkg::row_t'(1) << pn_reg);
                    end
                endcase
            end
            rag_pkg::S_UPD2_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = pn_reg;
                state_next = rag_pkg::S_UPD2_WR;
            end
            rag_pkg::S_UPD2_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = pn_reg;
                wr_data    = row & ~(rag_pkg::row_t'(1) << ln_reg);
                state_next = rag_pkg::S_ACK;
            end
            rag_pkg::S_ACK, rag_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    victim_next    = '0;
                    lock_next      = '0;
                    last_next      = 1'b1;
                    state_next     = rag_pkg::S_IDLE;
                end
            end
            rag_pkg::S_INIT:
            begin
                for (int k = 0; k < NN; k++)
                begin
                    vis_next[k] = rag_pkg::MARK_WHITE;
                end
                came_ok_next = '0;
                root_next    = '0;
                n_next       = '0;
                state_next   = rag_pkg::S_ROOT;
            end
            rag_pkg::S_ROOT:
            begin
                if (root_reg == CW'(NN))
                begin
                    state_next = rag_pkg::S_DONE;
                end
                else if (vrd != rag_pkg::MARK_WHITE)
                begin
                    root_next = root_reg + CW'(1);
                end
                else
                begin
                    vis_next[vaddr] = rag_pkg::MARK_GREY;
                    stack_next[0]   = vaddr;
                    ncol_next[0]    = '0;
                    sd_next         = CW'(1);
                    state_next      = rag_pkg::S_STEP;
                end
            end
            rag_pkg::S_STEP:
            begin
                if (sd_reg == '0)
                begin
                    root_next  = root_reg + CW'(1);
                    state_next = rag_pkg::S_ROOT;
                end
                else if (cc == CW'(NN))
                begin
                    vis_next[top] = rag_pkg::MARK_BLACK;
                    sd_next       = sd_reg - CW'(1);
                end
                else
                begin
                    ncol_next[sp] = cc + CW'(1);
                    rd_en         = 1'b1;
                    rd_addr       = top;
                    c_next        = cc[NW-1:0];
                    top_next      = top;
                    state_next    = rag_pkg::S_TEST;
                end
            end
            rag_pkg::S_TEST:
            begin
                state_next = rag_pkg::S_STEP;
                if (row[c_reg])
                begin
                    if (vrd == rag_pkg::MARK_WHITE)
                    begin
                        if (sd_reg < CW'(NN))
                        begin
                            came_next[c_reg]         = top_reg;
                            came_ok_next[c_reg]      = 1'b1;
                            vis_next[c_reg]          = rag_pkg::MARK_GREY;
                            stack_next[sd_reg[NW-1:0]] = c_reg;
                            ncol_next[sd_reg[NW-1:0]]  = '0;
                            sd_next                  = sd_reg + CW'(1);
                        end
                    end
                    else if (vrd == rag_pkg::MARK_GREY)
                    begin
                        came_next[c_reg]    = top_reg;
                        came_ok_next[c_reg] = 1'b1;
                        i_next              = c_reg;
                        steps_next          = '0;
                        chosen_ok_next      = 1'b0;
                        state_next          = rag_pkg::S_WALK;
                    end
                end
            end
            rag_pkg::S_WALK:
            begin
                if (steps_reg == CW'(NN) || !came_ok_reg[i_reg])
                begin
                    fin = 1'b1;
                end
                else
                begin
                    if (nx < NW'(rag_pkg::NUM_LOCKS))
                    begin
                        chosen_next    = nx;
                        chosen_ok_next = 1'b1;
                        ch_ok          = 1'b1;
                    end
                    i_next     = nx;
                    steps_next = steps_reg + CW'(1);
                    fin        = (nx == c_reg);
                end
                if (fin)
                begin
                    if (ch_ok)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = chosen_next;
                        state_next = rag_pkg::S_HOLD;
                    end
                    else
                    begin
                        state_next = rag_pkg::S_STEP;
                    end
                end
            end
            rag_pkg::S_HOLD:
            begin
                if (h_found)
                begin
                    holder_next = h;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                    clr_next    = '0;
                    state_next  = rag_pkg::S_CLEAR;
                end
                else
                begin
                    state_next = rag_pkg::S_STEP;
                end
            end
            rag_pkg::S_CLEAR:
            begin
                // write row clr, read row clr+1 in the same cycle
                wr_en   = 1'b1;
                wr_addr = clr_reg[NW-1:0];
                wr_data = (clr_reg[NW-1:0] == holder_reg) ? '0 : (row & ~cbit);
                if (clr_reg == CW'(NN - 1))
                begin
                    state_next = rag_pkg::S_REPORT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = NW'(clr_reg + CW'(1));
                    clr_next = clr_reg + CW'(1);
                end
            end
            rag_pkg::S_REPORT:
            begin
                if (n_reg >= rag_pkg::RES_W'(rag_pkg::RESULT_LIMIT - 1))
                begin
                    state_next = rag_pkg::S_STEP;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b1;
                    victim_next    = rag_pkg::PROC_W'(holder_reg - NW'(rag_pkg::NUM_LOCKS));
                    lock_next      = rag_pkg::LOCK_W'(chosen_reg);
                    last_next      = 1'b0;
                    n_next         = n_reg + rag_pkg::RES_W'(1);
                    state_next     = rag_pkg::S_STEP;
                end
            end
            default:
            begin
                state_next = rag_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rag_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            came_ok_reg   <= '0;
            root_reg      <= '0;
            sd_reg        <= '0;
            steps_reg     <= '0;
            clr_reg       <= '0;
            n_reg         <= '0;
            chosen_ok_reg <= 1'b0;
            for (int k = 0; k < NN; k++)
            begin
                vis_reg[k] <= rag_pkg::MARK_WHITE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            came_ok_reg   <= came_ok_next;
            root_reg      <= root_next;
            sd_reg        <= sd_next;
            steps_reg     <= steps_next;
            clr_reg       <= clr_next;
            n_reg         <= n_next;
            chosen_ok_reg <= chosen_ok_next;
            vis_reg       <= vis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pn_reg      <= pn_next;
        ln_reg      <= ln_next;
        came_reg    <= came_next;
        stack_reg   <= stack_next;
        ncol_reg    <= ncol_next;
        c_reg       <= c_next;
        top_reg     <= top_next;
        i_reg       <= i_next;
        chosen_reg  <= chosen_next;
        holder_reg  <= holder_next;
        found_reg   <= found_next;
        last_reg    <= last_next;
        victim_reg  <= victim_next;
        lock_reg    <= lock_next;
    end

    assign out_valid      = out_valid_reg;
    assign deadlock_found = found_reg;
    assign victim_proc    = victim_reg;
    assign freed_lock     = lock_reg;
    assign last           = last_reg;

`include "assert_macros.svh"
    `RAG_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_reg != rag_pkg::S_IDLE)
    `RAG_ASSERT_IMPL(a_depth_bound, 1'b1, sd_reg <= CW'(NN))
    `RAG_ASSERT_IMPL(a_result_room, 1'b1, n_reg <= rag_pkg::RES_W'(rag_pkg::RESULT_LIMIT - 1))
    `RAG_ASSERT_IMPL(a_found_not_last, out_valid && deadlock_found, !last)
endmodule
`default_nettype wire

// ===== dv/rag_deadlock_detector_test.sv =====
`timescale 1ns / 1ps

// Scoreboard: graph predictor plus queue of expected result beats.
class rag_scoreboard;
    typedef struct packed {
        logic       found;
        logic [4:0] victim;
        logic [3:0] lock;
        logic       fin;
    } beat_t;

    logic [29:0] adj [30];
    beat_t       pending [$];
    int          n_err;

    function new();
        foreach (adj[i]) adj[i] = '0;
        n_err = 0;
    endfunction

    // Back edge into grey node j: walk parents, pick last lock, kill its top holder.
    function automatic bit break_cycle(int j, ref int parent[30], output int victim,
                                       output int lock);
        int i, chosen, holder;
        i = j;
        chosen = -1;
        holder = -1;
        victim = 0;
        lock = 0;
        for (int s = 0; s < 30; s++)
        begin
            i = parent[i];
            if (i < 0) break;
            if (i < 10) chosen = i;
            if (i == j) break;
        end
        if (chosen < 0) return 0;
        for (int c = 10; c < 30; c++)
            if (adj[chosen][c]) holder = c;
        if (holder < 0) return 0;
        adj[holder] = '0;
        for (int c = 0; c < 30; c++) adj[c][holder] = 1'b0;
        victim = holder - 10;
        lock = chosen;
        return 1;
    endfunction

    function void note_input(rag_pkg::op_t op, logic [4:0] pid, logic [3:0] ln);
        int mark[30];
        int parent[30];
        int path[30];
        int col[30];
        int sd, top, c, v, l, n;
        if (op != rag_pkg::OP_DETECT)
        begin
            if (pid < 20 && ln < 10)
            begin
                case (op)
                    rag_pkg::OP_REQUEST: adj[10+pid][ln] = 1'b1;
                    rag_pkg::OP_ALLOC:
                    begin
                        adj[ln][10+pid] = 1'b1;
                        adj[10+pid][ln] = 1'b0;
                    end
                    default: adj[ln][10+pid] = 1'b0;
                endcase
            end
            pending.push_back('{1'b0, 5'd0, 4'd0, 1'b1});
            return;
        end
        n = 0;
        foreach (mark[i])
        begin
            mark[i] = rag_pkg::MARK_WHITE;
            parent[i] = -1;
        end
        for (int r = 0; r < 30; r++)
        begin
            if (mark[r] != rag_pkg::MARK_WHITE) continue;
            mark[r] = rag_pkg::MARK_GREY;
            path[0] = r;
            col[0] = 0;
            sd = 1;
            while (sd > 0)
            begin
                top = path[sd-1];
                c = col[sd-1];
                if (c >= 30)
                begin
                    mark[top] = rag_pkg::MARK_BLACK;
                    sd--;
                    continue;
                end
                col[sd-1] = c + 1;
                if (!adj[top][c]) continue;
                if (mark[c] == rag_pkg::MARK_WHITE)
                begin
                    if (sd < 30)
                    begin
                        parent[c] = top;
                        mark[c] = rag_pkg::MARK_GREY;
                        path[sd] = c;
                        col[sd] = 0;
                        sd++;
                    end
                end
                else if (mark[c] == rag_pkg::MARK_GREY)
                begin
                    parent[c] = top;
                    if (break_cycle(c, parent, v, l) && n < 20)
                    begin
                        pending.push_back('{1'b1, 5'(v), 4'(l), 1'b0});
                        n++;
                    end
                end
            end
        end
        pending.push_back('{1'b0, 5'd0, 4'd0, 1'b1});
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        n_err++;
    endtask

    task check_result(logic f, logic [4:0] v, logic [3:0] l, logic fin);
        beat_t e;
        if (pending.size() == 0)
        begin
            report($sformatf("unexpected beat f=%0d v=%0d l=%0d last=%0d", f, v, l, fin));
            return;
        end
        e = pending.pop_front();
        if (f !== e.found) report($sformatf("deadlock_found %0d want %0d", f, e.found));
        if (v !== e.victim) report($sformatf("victim_proc %0d want %0d", v, e.victim));
        if (l !== e.lock) report($sformatf("freed_lock %0d want %0d", l, e.lock));
        if (fin !== e.fin) report($sformatf("last %0d want %0d", fin, e.fin));
    endtask
endclass

module rag_deadlock_detector_test;
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] op = '0;
    logic [4:0] proc_id = '0;
    logic [3:0] lock_num = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       deadlock_found;
    logic [4:0] victim_proc;
    logic [3:0] freed_lock;
    logic       last;

    // idle/stall odds per hundred, changed per phase
    int send_idle = 0;
    int recv_stall = 0;
    longint cycles = 0;
    rag_scoreboard sb = new();

    rag_deadlock_detector DUT (.*);

    always #5 clk = ~clk;

    // Result side: random stall, check each accepted beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(deadlock_found, victim_proc, freed_lock, last);
            out_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    // Watchdog: ends the run with the error verdict once the cycle counter passes its limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 4000000)
        begin
            $display("rag_deadlock_detector_test: errors");
            $finish;
        end
    end

    // Send one beat; hold it until accepted. Optional idle cycles first.
    task automatic send(rag_pkg::op_t o, logic [4:0] p, logic [3:0] l);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        proc_id <= p;
        lock_num <= l;
        do @(posedge clk); while (in_stall);
        sb.note_input(o, p, l);
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Mostly build cycles: request/allocate/release over a small set of locks and procs.
    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            send(rag_pkg::OP_DETECT, 5'($urandom), 4'($urandom));
        else if (r < 17)
            send(rag_pkg::op_t'($urandom_range(2)), 5'($urandom), 4'($urandom));
        else
            send(rag_pkg::op_t'($urandom_range(2)), 5'($urandom_range(5)),
                 4'($urandom_range(3)));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: range extremes, out-of-range indexes, two-party deadlocks, a lock with two holders.
        send(rag_pkg::OP_REQUEST, 5'd0, 4'd0);
        send(rag_pkg::OP_ALLOC, 5'd19, 4'd9);
        send(rag_pkg::OP_REQUEST, 5'd19, 4'd0);
        send(rag_pkg::OP_REQUEST, 5'd20, 4'd3);   // bad proc: ack only
        send(rag_pkg::OP_ALLOC, 5'd31, 4'd15);    // bad both
        send(rag_pkg::OP_RELEASE, 5'd2, 4'd10);   // bad lock
        send(rag_pkg::OP_DETECT, 5'd0, 4'd0);     // no cycle
        send(rag_pkg::OP_ALLOC, 5'd0, 4'd0);
        send(rag_pkg::OP_REQUEST, 5'd0, 4'd9);
        send(rag_pkg::OP_DETECT, 5'd31, 4'd15);   // 0 holds 0, wants 9; 19 holds 9, wants 0
        send(rag_pkg::OP_RELEASE, 5'd0, 4'd0);
        send(rag_pkg::OP_ALLOC, 5'd1, 4'd1);
        send(rag_pkg::OP_ALLOC, 5'd2, 4'd1);      // two holders of lock 1
        send(rag_pkg::OP_REQUEST, 5'd1, 4'd2);
        send(rag_pkg::OP_ALLOC, 5'd2, 4'd2);
        send(rag_pkg::OP_REQUEST, 5'd2, 4'd1);
        send(rag_pkg::OP_DETECT, 5'd0, 4'd0);
        send(rag_pkg::OP_RELEASE, 5'd19, 4'd9);
        send(rag_pkg::OP_RELEASE, 5'd10, 4'd8);
        send(rag_pkg::OP_DETECT, 5'd0, 4'd0);

        // pause until drained
        go_quiet();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 81; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 81; end
                default: begin send_idle = 16; recv_stall = 16; end
            endcase
            repeat (73) random_item();
        end
        send_idle = 0;
        recv_stall = 0;
        go_quiet();
        repeat (50) @(posedge clk);

        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("rag_deadlock_detector_test: clean");
        else
            $display("rag_deadlock_detector_test: errors");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/rag_pkg.sv
rtl/rag_deadlock_detector.sv
dv/rag_deadlock_detector_test.sv
